// ===== rtl/sfl_pkg.sv =====
// Shared types and constants for the substring first/last matcher.
`default_nettype none
package sfl_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int HIST_DEPTH  = MAX_PATTERN - 1;
  localparam int POS_BITS    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8 * MAX_PATTERN;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CASE     = 3'd4;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes;
    logic [3:0]            pattern_length;
    logic [POS_BITS-1:0]   start_position;
    logic                  search_last;
    logic                  match_case;
  } cfg_t;

  typedef struct packed {
    logic                go;
    logic                eot;
    logic                window_match;
    logic [3:0]          len_sat;
  } step_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] match_position;
  } result_t;

  function automatic logic [3:0] sat_len(input logic [3:0] len);
    sat_len = (len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : len;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sfl_if.sv =====
// Valid/ready channel interfaces for text input and match results.
`default_nettype none
interface sfl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sfl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sfl_pkg::POS_BITS-1:0]  match_position;
  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfl_window.sv =====
// Byte history and parallel pattern compare over the current window.
`default_nettype none
module sfl_window (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic          eot,
  input  wire logic [7:0]    text_byte,
  input  wire sfl_pkg::cfg_t cfg,
  output sfl_pkg::step_t     step
);

  logic [7:0] hist_r [sfl_pkg::HIST_DEPTH];
  logic [7:0] win    [sfl_pkg::MAX_PATTERN];
  logic [3:0] len_sat;
  logic       match;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
    fold = (!exact && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  assign len_sat = sfl_pkg::sat_len(cfg.pattern_length);

  always_comb begin
    win[0] = text_byte;
    for (int i = 1; i < sfl_pkg::MAX_PATTERN; i++) begin
      win[i] = hist_r[i-1];
    end
  end

  always_comb begin
    logic [3:0] back;
    logic [7:0] pbyte;
    match = 1'b1;
    for (int j = 0; j < sfl_pkg::MAX_PATTERN; j++) begin
      back  = len_sat - 4'd1 - 4'(j);
      pbyte = cfg.pattern_bytes[8*j +: 8];
      if (4'(j) < len_sat &&
          fold(win[back[2:0]], cfg.match_case) != fold(pbyte, cfg.match_case)) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    step.go           = go;
    step.eot          = eot;
    step.window_match = match;
    step.len_sat      = len_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && eot)) begin
      for (int i = 0; i < sfl_pkg::HIST_DEPTH; i++) hist_r[i] <= 8'd0;
    end else if (go) begin
      hist_r[0] <= text_byte;
      for (int i = 1; i < sfl_pkg::HIST_DEPTH; i++) hist_r[i] <= hist_r[i-1];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfl_tracker.sv =====
// Position counter, first/last hit tracking and end-of-text result selection.
`default_nettype none
module sfl_tracker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sfl_pkg::step_t step,
  input  wire sfl_pkg::cfg_t  cfg,
  output sfl_pkg::result_t    result
);

  localparam int PB = sfl_pkg::POS_BITS;

  logic [PB:0]   pos_r, pos_nxt;
  logic          first_v_r, first_v_nxt;
  logic [PB-1:0] first_p_r, first_p_nxt;
  logic          any_v_r, any_v_nxt;
  logic [PB-1:0] any_p_r, any_p_nxt;
  logic          bnd_v_r, bnd_v_nxt;
  logic [PB-1:0] bnd_p_r, bnd_p_nxt;
  logic          hit;
  logic [PB-1:0] start;
  logic          sel_f;
  logic [PB-1:0] sel_p;

  assign hit = step.window_match && (step.len_sat != 4'd0) && !pos_r[PB] &&
               ({1'b0, pos_r} + (PB+2)'(1) >= (PB+2)'(step.len_sat));
  assign start = pos_r[PB-1:0] - PB'(step.len_sat) + PB'(1);

  always_comb begin
    first_v_nxt = first_v_r;
    first_p_nxt = first_p_r;
    any_v_nxt   = any_v_r;
    any_p_nxt   = any_p_r;
    bnd_v_nxt   = bnd_v_r;
    bnd_p_nxt   = bnd_p_r;
    if (hit) begin
      if (!first_v_r && start >= cfg.start_position) begin
        first_v_nxt = 1'b1;
        first_p_nxt = start;
      end
      any_v_nxt = 1'b1;
      any_p_nxt = start;
      if (pos_r[PB-1:0] < cfg.start_position) begin
        bnd_v_nxt = 1'b1;
        bnd_p_nxt = start;
      end
    end
    pos_nxt = pos_r[PB] ? pos_r : pos_r + (PB+1)'(1);
  end

  always_comb begin
    if (!cfg.search_last) begin
      sel_f = first_v_nxt;
      sel_p = first_p_nxt;
    end else if ({1'b0, cfg.start_position} < pos_nxt) begin
      sel_f = bnd_v_nxt;
      sel_p = bnd_p_nxt;
    end else begin
      sel_f = any_v_nxt;
      sel_p = any_p_nxt;
    end
    result.found          = sel_f;
    result.match_position = sel_f ? sel_p : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step.go && step.eot)) begin
      pos_r     <= '0;
      first_v_r <= 1'b0;
      first_p_r <= '0;
      any_v_r   <= 1'b0;
      any_p_r   <= '0;
      bnd_v_r   <= 1'b0;
      bnd_p_r   <= '0;
    end else if (step.go) begin
      pos_r     <= pos_nxt;
      first_v_r <= first_v_nxt;
      first_p_r <= first_p_nxt;
      any_v_r   <= any_v_nxt;
      any_p_r   <= any_p_nxt;
      bnd_v_r   <= bnd_v_nxt;
      bnd_p_r   <= bnd_p_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/substring_first_last_matcher.sv =====
// Top level of the substring first/last matcher.
//
// Usage: text bytes arrive on in_chan (valid/ready), one per transaction, with
// end_of_text set on the last byte of a text. The block compares the window
// ending at each byte against a pattern of 1 to 8 bytes set through the
// cfg_ write port (pattern, length, start position, first/last mode, case).
// One result transaction (found, match_position) leaves on out_chan for each
// end-of-text byte; other bytes produce none.
// Path: an accepted byte is held in the input register for the window compare
// and hit update, and an end-of-text byte's result loads the output register.
// Throughput: one byte per cycle except while an end-of-text byte is held;
// the window compare and hit update between the registers are combinational.
// Stall: while a result waits on out_chan, bytes without end_of_text keep
// flowing; an end-of-text byte holds in the input register until the output
// register frees, and in_chan.ready stays low while that byte is held.
// Reset: rst_n (synchronous, active low) empties both registers, clears text
// state and loads register defaults (length 1, exact case, first mode).
// Configuration must be written by the user only while no text is in
// progress; the block itself does not enforce this.
`default_nettype none
module substring_first_last_matcher (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  sfl_in_if.sink                                in_chan,
  sfl_out_if.source                             out_chan,
  input  wire logic                             cfg_wr_en,
  input  wire logic [sfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sfl_pkg::cfg_t    cfg_r;
  sfl_pkg::step_t   step;
  sfl_pkg::result_t result;

  logic                        in_valid_r;
  logic [7:0]                  in_byte_r;
  logic                        in_eot_r;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [sfl_pkg::POS_BITS-1:0] out_pos_r;
  logic                        go;
  logic                        in_take;

  assign go      = in_valid_r && (!in_eot_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || go;
  assign in_take = in_chan.valid && in_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = out_found_r;
  assign out_chan.match_position = out_pos_r;

  sfl_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .eot       (in_eot_r),
    .text_byte (in_byte_r),
    .cfg       (cfg_r),
    .step      (step)
  );

  sfl_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= 4'd1;
      cfg_r.start_position <= '0;
      cfg_r.search_last    <= 1'b0;
      cfg_r.match_case     <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sfl_pkg::REG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= cfg_wdata;
        sfl_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[3:0];
        sfl_pkg::REG_START_POSITION:
          cfg_r.start_position <= cfg_wdata[sfl_pkg::POS_BITS-1:0];
        sfl_pkg::REG_SEARCH_LAST:    cfg_r.search_last    <= cfg_wdata[0];
        sfl_pkg::REG_MATCH_CASE:     cfg_r.match_case     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_take) begin
      in_byte_r <= in_chan.text_byte;
      in_eot_r  <= in_chan.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && in_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (go && in_eot_r) begin
      out_found_r <= result.found;
      out_pos_r   <= result.match_position;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_substring_first_last_matcher.sv =====
// Testbench for the substring first/last matcher: randomized texts checked against a predictor.
`timescale 1ns / 1ps
module tb_substring_first_last_matcher;
  import sfl_pkg::*;

  localparam int POS_LIMIT = 1 << POS_BITS;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sfl_in_if  in_if ();
  sfl_out_if out_if ();

  substring_first_last_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  text_item_t pending_items [$];
  result_t    expected_results [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_arm = 1'b0;
  logic       hold_done;
  int         hold_left;

  cfg_t       shadow;
  logic [7:0] recent_text [HIST_DEPTH];
  logic [16:0] text_pos;
  logic        first_valid, any_valid, bounded_valid;
  logic [15:0] first_pos, any_pos, bounded_pos;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (!shadow.match_case && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] boundary_chars [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return boundary_chars[$urandom_range(0, 7)];
  endfunction

  task automatic clear_text();
    for (int k = 0; k < HIST_DEPTH; k++) begin
      recent_text[k] = 8'h00;
    end
    text_pos = '0;
    first_valid = 1'b0;
    first_pos = '0;
    any_valid = 1'b0;
    any_pos = '0;
    bounded_valid = 1'b0;
    bounded_pos = '0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eot);
    logic [3:0]  len;
    logic [16:0] idx;
    logic [16:0] first_at;
    logic        hit;
    int          back;
    logic [7:0]  t;
    logic        f;
    logic [15:0] pos;
    result_t     res;
    len = (shadow.pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : shadow.pattern_length;
    idx = text_pos;
    if (len != 0 && idx < POS_LIMIT && idx + 17'd1 >= len) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        back = len - 1 - j;
        t = (back == 0) ? b : recent_text[back - 1];
        if (fold_char(t) != fold_char(shadow.pattern_bytes[8*j +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        first_at = idx + 17'd1 - len;
        if (!first_valid && first_at >= shadow.start_position) begin
          first_valid = 1'b1;
          first_pos = first_at[15:0];
        end
        any_valid = 1'b1;
        any_pos = first_at[15:0];
        if (idx < shadow.start_position) begin
          bounded_valid = 1'b1;
          bounded_pos = first_at[15:0];
        end
      end
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      recent_text[k] = recent_text[k - 1];
    end
    recent_text[0] = b;
    if (idx < POS_LIMIT) begin
      text_pos = idx + 17'd1;
    end
    if (eot) begin
      if (!shadow.search_last) begin
        f = first_valid;
        pos = first_pos;
      end else if (shadow.start_position < text_pos) begin
        f = bounded_valid;
        pos = bounded_pos;
      end else begin
        f = any_valid;
        pos = any_pos;
      end
      res.found = f;
      res.match_position = f ? pos : '0;
      expected_results.push_back(res);
      clear_text();
    end
  endtask

  task automatic add_item(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    pending_items.push_back(it);
  endtask

  task automatic add_random_text(input int n);
    int         i = 0;
    int         len;
    logic [7:0] c;
    len = (shadow.pattern_length > 4'(MAX_PATTERN)) ? MAX_PATTERN : shadow.pattern_length;
    while (i < n) begin
      if (len != 0 && $urandom_range(0, 99) < 15) begin
        for (int j = 0; j < len && i < n; j++) begin
          c = shadow.pattern_bytes[8*j +: 8];
          if ($urandom_range(0, 3) == 0) begin
            c = c ^ 8'h20;
          end
          add_item(c, i == n - 1);
          i++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: c = shadow.pattern_bytes[8*$urandom_range(0, 7) +: 8];
          1: c = pick_char();
          default: c = 8'($urandom_range(0, 255));
        endcase
        add_item(c, i == n - 1);
        i++;
      end
    end
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PATTERN_BYTES:  shadow.pattern_bytes = value;
      REG_PATTERN_LENGTH: shadow.pattern_length = value[3:0];
      REG_START_POSITION: shadow.start_position = value[POS_BITS-1:0];
      REG_SEARCH_LAST:    shadow.search_last = value[0];
      REG_MATCH_CASE:     shadow.match_case = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // driver: predict on each accepted transaction, then offer the next item
  always @(posedge clk) begin : drive_proc
    text_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_byte(in_if.text_byte, in_if.end_of_text);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.text_byte <= nxt.text_byte;
          in_if.end_of_text <= nxt.end_of_text;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, actual found=%0b pos=%0d",
                   $time, out_if.found, out_if.match_position);
        end else begin
          want = expected_results.pop_front();
          if (out_if.found !== want.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, out_if.found);
          end
          if (out_if.match_position !== want.match_position) begin
            mismatches++;
            $display("%0t: match_position mismatch, expected %0d, actual %0d",
                     $time, want.match_position, out_if.match_position);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : main_proc
    logic [CFG_DATA_W-1:0] v;
    logic [CFG_DATA_W-1:0] pat;
    int r;
    in_if.valid = 1'b0;
    in_if.text_byte = 8'h00;
    in_if.end_of_text = 1'b0;
    out_if.ready = 1'b0;
    shadow = '0;
    shadow.pattern_length = 4'd1;
    shadow.match_case = 1'b1;
    clear_text();
    send_idle_pct = 23;
    recv_idle_pct = 68;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single zero byte pattern
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b1);
    wait_idle();

    set_register(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_6241);
    set_register(REG_PATTERN_LENGTH, 64'd2);
    set_register(REG_MATCH_CASE, 64'd0);
    add_item(8'h61, 1'b0);
    add_item(8'h42, 1'b0);
    add_item(8'h78, 1'b1);
    add_item(8'h61, 1'b1);
    wait_idle();

    set_register(REG_MATCH_CASE, 64'd1);
    add_item(8'h61, 1'b0);
    add_item(8'h62, 1'b1);
    add_item(8'h41, 1'b0);
    add_item(8'h62, 1'b1);
    wait_idle();

    set_register(REG_SEARCH_LAST, 64'd1);
    set_register(REG_START_POSITION, 64'd3);
    for (int k = 0; k < 6; k++) begin
      add_item((k % 2 == 0) ? 8'h41 : 8'h62, k == 5);
    end
    wait_idle();
    set_register(REG_START_POSITION, 64'd1);
    add_item(8'h41, 1'b0);
    add_item(8'h62, 1'b1);
    wait_idle();

    set_register(REG_PATTERN_LENGTH, 64'd0);
    add_item(8'h41, 1'b0);
    add_item(8'h62, 1'b1);
    wait_idle();

    set_register(REG_PATTERN_BYTES, '1);
    set_register(REG_PATTERN_LENGTH, 64'd12);
    set_register(REG_SEARCH_LAST, 64'd0);
    set_register(REG_START_POSITION, 64'd0);
    set_register(REG_MATCH_CASE, 64'd0);
    for (int k = 0; k < 8; k++) begin
      add_item(8'hFF, k == 7);
    end
    wait_idle();

    for (int k = 0; k < 3; k++) begin
      set_register(REG_MATCH_CASE + CFG_IDX_W'(1 + k), {$urandom(), $urandom()});
    end

    for (int grp = 0; grp < 3; grp++) begin
      case (grp)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 6; ph++) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          pat[8*k +: 8] = pick_char();
        end
        set_register(REG_PATTERN_BYTES, pat);
        r = $urandom_range(0, 19);
        v = {$urandom(), $urandom()};
        if (r < 16) begin
          v[3:0] = 4'($urandom_range(1, 8));
        end else if (r == 16) begin
          v[3:0] = 4'd0;
        end else if (r == 17) begin
          v[3:0] = 4'(MAX_PATTERN);
        end else begin
          v[3:0] = 4'($urandom_range(9, 15));
        end
        set_register(REG_PATTERN_LENGTH, v);
        r = $urandom_range(0, 9);
        v = {$urandom(), $urandom()};
        if (r < 7) begin
          v[15:0] = 16'($urandom_range(0, 20));
        end else if (r == 7) begin
          v[15:0] = 16'hFFFF;
        end else if (r == 8) begin
          v[15:0] = 16'h0000;
        end else begin
          v[15:0] = 16'($urandom_range(0, 65535));
        end
        set_register(REG_START_POSITION, v);
        set_register(REG_SEARCH_LAST, {$urandom(), $urandom()});
        set_register(REG_MATCH_CASE, {$urandom(), $urandom()});
        if (grp == 2 && ph == 1) begin
          hold_arm = 1'b1;
        end
        repeat (8) add_random_text($urandom_range(1, 16));
        wait_idle();
      end
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
